// ===== hdl/tpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfc_pkg
// Shared types and constants of the texture pixel format converter: codes for
// operations, source formats, register indexes and queued work kinds.
// ----------------------------------------------------------------------------
package tpfc_pkg;

   localparam int IDX_W       = 16;
   localparam int REP_W       = 4;
   localparam int FMT_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   // effective copies of each yuy16 pixel never exceed this
   localparam logic [REP_W-1:0] REP_CAP = 4'd8;

   // alpha byte of opaque results and the table pages of the channel map
   localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;
   localparam logic [9:0] MAP_GREEN_BASE = 10'h100;
   localparam logic [9:0] MAP_RED_BASE   = 10'h200;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   localparam logic [FMT_W-1:0] FMT_PAL_OPAQUE = 3'd0;
   localparam logic [FMT_W-1:0] FMT_PAL_ALPHA  = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGB32      = 3'd2;
   localparam logic [FMT_W-1:0] FMT_ARGB32     = 3'd3;
   localparam logic [FMT_W-1:0] FMT_YUY16      = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_COLOR_MAP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_COUNT  = 2'd2;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_WRITE      = 3'd0;
   localparam kind_type KIND_PAL_OPAQUE = 3'd1;
   localparam kind_type KIND_PAL_ALPHA  = 3'd2;
   localparam kind_type KIND_RGB        = 3'd3;
   localparam kind_type KIND_ARGB       = 3'd4;
   localparam kind_type KIND_YUY        = 3'd5;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one unit of work passed from the front to the back
   typedef struct packed {
      kind_type         kind;
      logic             map;   // channel or luma map through the table
      logic [31:0]      word;  // table data for a write, else the pixel
      logic [15:0]      aux;   // first pixel of a yuy16 pair
      logic [IDX_W-1:0] addr;  // table address, already wrapped
      logic [REP_W-1:0] rep;   // copies of each yuy16 pixel
   } entry_type;

   typedef struct packed {
      logic [FMT_W-1:0] source_format;
      logic             use_color_map;
      logic [REP_W-1:0] repeat_count;
   } cfg_type;

endpackage

// ===== hdl/tpfc_front.sv =====
// ----------------------------------------------------------------------------
// tpfc_front
// Accepts request beats, classifies them by opcode and format, tracks yuy16
// pairing and wraps table addresses to the table depth before queueing.
// ----------------------------------------------------------------------------
module tpfc_front #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpfc_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [15:0]                         req_table_index,
   input  logic [31:0]                         req_table_value,
   input  logic [31:0]                         req_pixel_word,
   input  logic                                req_line_start,
   input  logic [tpfc_pkg::QUEUE_CNT_W-1:0]    queue_count,
   output logic                                push_valid,
   output tpfc_pkg::entry_type                 push_entry
);

   // wrap by reciprocal multiply: quotient estimate is exact or one short
   localparam longint unsigned RECIP  = 64'h1_0000_0000 / TABLE_DEPTH;
   localparam int              PROD_W = tpfc_pkg::IDX_W + $clog2(RECIP + 1);
   localparam int              QUO_W  = PROD_W - 32;
   localparam int              REM_W  = tpfc_pkg::IDX_W + 2;
   localparam logic [PROD_W-1:0] RECIP_V = PROD_W'(RECIP);
   localparam logic [REM_W-1:0]  DEPTH_V = REM_W'(TABLE_DEPTH);
   localparam int              SUM_W  = tpfc_pkg::QUEUE_CNT_W + 1;

   logic                          accept;
   logic                          take;
   logic                          phase_eff;
   logic [tpfc_pkg::REP_W-1:0]    rep_eff;
   logic [tpfc_pkg::IDX_W-1:0]    idx;
   tpfc_pkg::entry_type           ent;
   logic [QUO_W-1:0]              quo;
   logic [SUM_W-1:0]              inflight;

   logic                          f1_valid_ff, f1_valid_in;
   tpfc_pkg::entry_type           f1_entry_ff, f1_entry_in;
   logic [tpfc_pkg::IDX_W-1:0]    f1_idx_ff, f1_idx_in;
   logic [PROD_W-1:0]             f1_prod_ff, f1_prod_in;
   logic                          f2_valid_ff, f2_valid_in;
   tpfc_pkg::entry_type           f2_entry_ff, f2_entry_in;
   logic [REM_W-1:0]              f2_rem_ff, f2_rem_in;
   logic [15:0]                   pend_ff, pend_in;
   logic                          phase_ff, phase_in;

   // hold off when the queue could not absorb every beat already in flight
   assign inflight  = SUM_W'(queue_count) + SUM_W'(f1_valid_ff) + SUM_W'(f2_valid_ff);
   assign req_stall = inflight >= SUM_W'(tpfc_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      take      = 1'b0;
      phase_eff = req_line_start ? 1'b0 : phase_ff;
      pend_in   = pend_ff;
      phase_in  = phase_ff;
      idx       = req_pixel_word[15:0];
      if (cfg.repeat_count == '0) begin
         rep_eff = tpfc_pkg::REP_W'(1);
      end else if (cfg.repeat_count > tpfc_pkg::REP_CAP) begin
         rep_eff = tpfc_pkg::REP_CAP;
      end else begin
         rep_eff = cfg.repeat_count;
      end
      ent.kind = tpfc_pkg::KIND_WRITE;
      ent.map  = cfg.use_color_map;
      ent.word = req_pixel_word;
      ent.aux  = pend_ff;
      ent.addr = '0;
      ent.rep  = rep_eff;

      if (req_opcode == tpfc_pkg::OP_WRITE) begin
         take     = 1'b1;
         ent.word = req_table_value;
         idx      = req_table_index;
      end else begin
         if (req_line_start) begin
            phase_in = 1'b0;
         end
         unique case (cfg.source_format)
            tpfc_pkg::FMT_PAL_OPAQUE: begin
               take     = 1'b1;
               ent.kind = tpfc_pkg::KIND_PAL_OPAQUE;
            end
            tpfc_pkg::FMT_PAL_ALPHA: begin
               take     = 1'b1;
               ent.kind = tpfc_pkg::KIND_PAL_ALPHA;
            end
            tpfc_pkg::FMT_RGB32: begin
               take     = 1'b1;
               ent.kind = tpfc_pkg::KIND_RGB;
            end
            tpfc_pkg::FMT_ARGB32: begin
               take     = 1'b1;
               ent.kind = tpfc_pkg::KIND_ARGB;
            end
            tpfc_pkg::FMT_YUY16: begin
               if (!phase_eff) begin
                  // first of a pair: keep it, nothing to emit yet
                  pend_in  = req_pixel_word[15:0];
                  phase_in = 1'b1;
               end else begin
                  take     = 1'b1;
                  ent.kind = tpfc_pkg::KIND_YUY;
                  phase_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (!accept) begin
         pend_in  = pend_ff;
         phase_in = phase_ff;
      end

      f1_valid_in = accept && take;
      f1_entry_in = ent;
      f1_idx_in   = idx;
      f1_prod_in  = PROD_W'(idx) * RECIP_V;

      quo         = f1_prod_ff[PROD_W-1:32];
      f2_valid_in = f1_valid_ff;
      f2_entry_in = f1_entry_ff;
      f2_rem_in   = REM_W'(f1_idx_ff) - REM_W'(REM_W'(quo) * DEPTH_V);

      push_entry  = f2_entry_ff;
      if (f2_rem_ff >= DEPTH_V) begin
         push_entry.addr = tpfc_pkg::IDX_W'(f2_rem_ff - DEPTH_V);
      end else begin
         push_entry.addr = tpfc_pkg::IDX_W'(f2_rem_ff);
      end
   end

   assign push_valid = f2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         pend_ff     <= '0;
         phase_ff    <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
         pend_ff     <= pend_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_entry_ff <= f1_entry_in;
      f1_idx_ff   <= f1_idx_in;
      f1_prod_ff  <= f1_prod_in;
      f2_entry_ff <= f2_entry_in;
      f2_rem_ff   <= f2_rem_in;
   end

endmodule

// ===== hdl/tpfc_queue.sv =====
// ----------------------------------------------------------------------------
// tpfc_queue
// Short first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module tpfc_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_valid,
   input  tpfc_pkg::entry_type               push_entry,
   input  logic                              pop,
   output logic                              head_valid,
   output tpfc_pkg::entry_type               head_entry,
   output logic [tpfc_pkg::QUEUE_CNT_W-1:0]  count
);

   tpfc_pkg::entry_type                   slots_ff [tpfc_pkg::QUEUE_DEPTH];
   logic [tpfc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tpfc_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tpfc_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                  pop_eff;

   assign head_valid = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign pop_eff    = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = tpfc_pkg::QUEUE_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop_eff) begin
         rd_ptr_in = tpfc_pkg::QUEUE_PTR_W'(rd_ptr_ff + 1'b1);
      end
      unique case ({push_valid, pop_eff})
         2'b10:   count_in = tpfc_pkg::QUEUE_CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = tpfc_pkg::QUEUE_CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/tpfc_back.sv =====
// ----------------------------------------------------------------------------
// tpfc_back
// Executes queued work: owns the color table, performs table writes and
// lookups, does the yuy16 colour conversion and repeats result beats.
// ----------------------------------------------------------------------------
module tpfc_back #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tpfc_pkg::entry_type  head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_pixel_out,
   output logic                 rsp_last_of_run
);

   localparam int AW = $clog2(TABLE_DEPTH);

   localparam logic signed [19:0] K_Y        = 20'sd298;
   localparam logic signed [19:0] K_RV       = 20'sd409;
   localparam logic signed [19:0] K_GU       = 20'sd100;
   localparam logic signed [19:0] K_GV       = 20'sd208;
   localparam logic signed [19:0] K_BU       = 20'sd516;
   localparam logic signed [19:0] LUMA_OFS   = 20'sd4768;
   localparam logic signed [19:0] CHROMA_MID = 20'sd128;
   localparam logic signed [19:0] ROUNDING   = 20'sd128;

   function automatic logic [7:0] clip_chan(input logic signed [19:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v[18:16] != 3'd0) begin
         res = 8'hff;
      end else begin
         res = v[15:8];
      end
      return res;
   endfunction

   function automatic logic [31:0] yuv_pixel(input logic signed [19:0] c,
                                             input logic signed [19:0] tr,
                                             input logic signed [19:0] tg,
                                             input logic signed [19:0] tb);
      return {8'hff, clip_chan(c + tr + ROUNDING), clip_chan(c + tg + ROUNDING),
              clip_chan(c + tb + ROUNDING)};
   endfunction

   logic [31:0]           table_mem [TABLE_DEPTH];
   logic [31:0]           rd0_ff, rd1_ff;
   logic [AW-1:0]         ra0, ra1;

   logic                  adv;
   logic                  two_step;
   logic                  em_ready;
   logic                  last;
   logic [31:0]           mapped;
   logic [31:0]           pix;
   logic [7:0]            y0, y1;
   logic signed [19:0]    d20, e20;
   logic [31:0]           yuv0, yuv1;

   logic                  step_ff, step_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_part_ff, s2_part_in;
   tpfc_pkg::entry_type   s2_ent_ff, s2_ent_in;
   logic [31:0]           acc_ff, acc_in;
   logic                  s3_valid_ff, s3_valid_in;
   logic                  s3_yuy_ff, s3_yuy_in;
   logic [tpfc_pkg::REP_W-1:0] s3_rep_ff, s3_rep_in;
   logic [31:0]           s3_pix_ff, s3_pix_in;
   logic signed [19:0]    s3_c0_ff, s3_c0_in;
   logic signed [19:0]    s3_c1_ff, s3_c1_in;
   logic signed [19:0]    s3_tr_ff, s3_tr_in;
   logic signed [19:0]    s3_tg_ff, s3_tg_in;
   logic signed [19:0]    s3_tb_ff, s3_tb_in;
   logic                  em_valid_ff, em_valid_in;
   logic                  em_second_ff, em_second_in;
   logic [tpfc_pkg::REP_W-1:0] em_cnt_ff, em_cnt_in;
   logic [tpfc_pkg::REP_W-1:0] em_rep_ff, em_rep_in;
   logic [31:0]           em_cur_ff, em_cur_in;
   logic [31:0]           em_nxt_ff, em_nxt_in;

   // the whole back pipeline moves together when the emitter can take
   assign last     = !em_second_ff && (em_cnt_ff == tpfc_pkg::REP_W'(1));
   assign em_ready = !em_valid_ff || (!rsp_stall && last);
   assign adv      = !s3_valid_ff || em_ready;

   assign two_step = head_entry.map &&
                     ((head_entry.kind == tpfc_pkg::KIND_RGB) ||
                      (head_entry.kind == tpfc_pkg::KIND_ARGB));
   assign pop      = adv && head_valid && (!two_step || step_ff);

   // issue: pick table read addresses for the head entry
   always_comb begin
      ra0 = '0;
      ra1 = '0;
      unique case (head_entry.kind)
         tpfc_pkg::KIND_PAL_OPAQUE, tpfc_pkg::KIND_PAL_ALPHA: begin
            ra0 = AW'(head_entry.addr);
         end
         tpfc_pkg::KIND_RGB, tpfc_pkg::KIND_ARGB: begin
            if (!step_ff) begin
               ra0 = AW'(tpfc_pkg::MAP_RED_BASE + {2'b00, head_entry.word[23:16]});
               ra1 = AW'(tpfc_pkg::MAP_GREEN_BASE + {2'b00, head_entry.word[15:8]});
            end else begin
               ra0 = AW'(head_entry.word[7:0]);
            end
         end
         tpfc_pkg::KIND_YUY: begin
            ra0 = AW'(head_entry.aux[15:8]);
            ra1 = AW'(head_entry.word[15:8]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (head_valid && (head_entry.kind == tpfc_pkg::KIND_WRITE)) begin
            table_mem[AW'(head_entry.addr)] <= head_entry.word;
         end
         rd0_ff <= table_mem[ra0];
         rd1_ff <= table_mem[ra1];
      end
   end

   always_comb begin
      // issue to read stage
      step_in     = step_ff;
      s2_valid_in = s2_valid_ff;
      s2_part_in  = s2_part_ff;
      s2_ent_in   = s2_ent_ff;
      if (adv) begin
         if (head_valid && two_step) begin
            step_in = !step_ff;
         end
         s2_valid_in = head_valid && (head_entry.kind != tpfc_pkg::KIND_WRITE);
         s2_part_in  = two_step && !step_ff;
         s2_ent_in   = head_entry;
      end

      // read stage to compute stage
      mapped = acc_ff | rd0_ff;
      unique case (s2_ent_ff.kind)
         tpfc_pkg::KIND_PAL_OPAQUE: pix = {tpfc_pkg::ALPHA_OPAQUE, rd0_ff[23:0]};
         tpfc_pkg::KIND_PAL_ALPHA:  pix = rd0_ff;
         tpfc_pkg::KIND_RGB: begin
            pix = {tpfc_pkg::ALPHA_OPAQUE,
                   s2_ent_ff.map ? mapped[23:0] : s2_ent_ff.word[23:0]};
         end
         tpfc_pkg::KIND_ARGB: begin
            pix = s2_ent_ff.map ? ({s2_ent_ff.word[31:24], 24'd0} | mapped)
                                : s2_ent_ff.word;
         end
         default: pix = s2_ent_ff.word;
      endcase

      y0  = s2_ent_ff.map ? rd0_ff[7:0] : s2_ent_ff.aux[15:8];
      y1  = s2_ent_ff.map ? rd1_ff[7:0] : s2_ent_ff.word[15:8];
      d20 = $signed(20'(s2_ent_ff.aux[7:0])) - CHROMA_MID;
      e20 = $signed(20'(s2_ent_ff.word[7:0])) - CHROMA_MID;

      acc_in      = acc_ff;
      s3_valid_in = s3_valid_ff;
      s3_yuy_in   = s3_yuy_ff;
      s3_rep_in   = s3_rep_ff;
      s3_pix_in   = s3_pix_ff;
      s3_c0_in    = s3_c0_ff;
      s3_c1_in    = s3_c1_ff;
      s3_tr_in    = s3_tr_ff;
      s3_tg_in    = s3_tg_ff;
      s3_tb_in    = s3_tb_ff;
      if (adv) begin
         // first beat of a channel map: hold red and green lookups
         if (s2_valid_ff && s2_part_ff) begin
            acc_in = rd0_ff | rd1_ff;
         end
         s3_valid_in = s2_valid_ff && !s2_part_ff;
         s3_yuy_in   = s2_ent_ff.kind == tpfc_pkg::KIND_YUY;
         s3_rep_in   = s2_ent_ff.rep;
         s3_pix_in   = pix;
         s3_c0_in    = $signed(20'(y0)) * K_Y - LUMA_OFS;
         s3_c1_in    = $signed(20'(y1)) * K_Y - LUMA_OFS;
         s3_tr_in    = e20 * K_RV;
         s3_tg_in    = -(d20 * K_GU) - (e20 * K_GV);
         s3_tb_in    = d20 * K_BU;
      end

      // emitter
      yuv0         = yuv_pixel(s3_c0_ff, s3_tr_ff, s3_tg_ff, s3_tb_ff);
      yuv1         = yuv_pixel(s3_c1_ff, s3_tr_ff, s3_tg_ff, s3_tb_ff);
      em_valid_in  = em_valid_ff;
      em_second_in = em_second_ff;
      em_cnt_in    = em_cnt_ff;
      em_rep_in    = em_rep_ff;
      em_cur_in    = em_cur_ff;
      em_nxt_in    = em_nxt_ff;
      if (s3_valid_ff && em_ready) begin
         em_valid_in  = 1'b1;
         em_second_in = s3_yuy_ff;
         em_cnt_in    = s3_yuy_ff ? s3_rep_ff : tpfc_pkg::REP_W'(1);
         em_rep_in    = s3_rep_ff;
         em_cur_in    = s3_yuy_ff ? yuv0 : s3_pix_ff;
         em_nxt_in    = yuv1;
      end else if (em_valid_ff && !rsp_stall) begin
         if (em_cnt_ff == tpfc_pkg::REP_W'(1)) begin
            if (em_second_ff) begin
               // advance to the copies of the second pixel of the pair
               em_cur_in    = em_nxt_ff;
               em_cnt_in    = em_rep_ff;
               em_second_in = 1'b0;
            end else begin
               em_valid_in = 1'b0;
            end
         end else begin
            em_cnt_in = tpfc_pkg::REP_W'(em_cnt_ff - 1'b1);
         end
      end
   end

   assign rsp_valid       = em_valid_ff;
   assign rsp_pixel_out   = em_cur_ff;
   assign rsp_last_of_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_part_ff   <= 1'b0;
         s3_valid_ff  <= 1'b0;
         em_valid_ff  <= 1'b0;
         em_second_ff <= 1'b0;
         em_cnt_ff    <= tpfc_pkg::REP_W'(1);
      end else begin
         step_ff      <= step_in;
         s2_valid_ff  <= s2_valid_in;
         s2_part_ff   <= s2_part_in;
         s3_valid_ff  <= s3_valid_in;
         em_valid_ff  <= em_valid_in;
         em_second_ff <= em_second_in;
         em_cnt_ff    <= em_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ent_ff <= s2_ent_in;
      acc_ff    <= acc_in;
      s3_yuy_ff <= s3_yuy_in;
      s3_rep_ff <= s3_rep_in;
      s3_pix_ff <= s3_pix_in;
      s3_c0_ff  <= s3_c0_in;
      s3_c1_ff  <= s3_c1_in;
      s3_tr_ff  <= s3_tr_in;
      s3_tg_ff  <= s3_tg_in;
      s3_tb_ff  <= s3_tb_in;
      em_rep_ff <= em_rep_in;
      em_cur_ff <= em_cur_in;
      em_nxt_ff <= em_nxt_in;
   end

endmodule

// ===== hdl/texture_pixel_format_converter_unit.sv =====
// Path: the front wrap stages, the queue, the table read, the compute stage
//   and the emitter; a channel-mapped rgb32 or argb32 pixel (three lookups on
//   two read ports) reads red and green, then blue. Throughput: one request
//   beat per cycle unless stalled; a yuy16 pair emits 2 x repeat_count (1..8) beats.
// Reset: clears pipeline control, yuy16 pairing and the registers to format
//   0, map off, repeat 1. Table contents stay undefined; no clearing pass.
// ----------------------------------------------------------------------------
// texture_pixel_format_converter_unit
// Converts texture pixels in palette, rgb32, argb32 and yuy16 formats into
// 32-bit ARGB result beats, with a color table loaded through write beats.
// ----------------------------------------------------------------------------
module texture_pixel_format_converter_unit #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_write_en,
   input  logic [tpfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tpfc_pkg::CSR_DATA_W-1:0]     csr_write_data,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [15:0]                         req_table_index,
   input  logic [31:0]                         req_table_value,
   input  logic [31:0]                         req_pixel_word,
   input  logic                                req_line_start,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_pixel_out,
   output logic                                rsp_last_of_run
);

   // Front: takes a request beat every cycle the queue has room for it and
   // everything already in flight. Classifies it from the registers, pairs
   // yuy16 pixels (first of a pair is parked there; an unused format drops the
   // beat) and wraps table addresses over two stages.
   //
   // Queue: eight entries; the front stall is worked out from its fill and
   // the two front stages, so nothing is ever pushed into a full queue.
   //
   // Back: one pipeline advancing as a whole whenever the result emitter can
   // take the next entry. Table writes land in issue order, so lookups that
   // follow a write always see it. The emitter holds a result beat while the
   // consumer stalls and loads the next entry on the same edge its last
   // beat is taken.

   tpfc_pkg::cfg_type                        cfg_ff, cfg_in;
   logic                                     push_valid;
   tpfc_pkg::entry_type                      push_entry;
   logic                                     pop;
   logic                                     head_valid;
   tpfc_pkg::entry_type                      head_entry;
   logic [tpfc_pkg::QUEUE_CNT_W-1:0]         queue_count;

   // configuration writes; indexes past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tpfc_pkg::CSR_SOURCE_FORMAT: begin
               cfg_in.source_format = csr_write_data[tpfc_pkg::FMT_W-1:0];
            end
            tpfc_pkg::CSR_USE_COLOR_MAP: begin
               cfg_in.use_color_map = csr_write_data[0];
            end
            tpfc_pkg::CSR_REPEAT_COUNT: begin
               cfg_in.repeat_count = csr_write_data[tpfc_pkg::REP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format <= tpfc_pkg::FMT_PAL_OPAQUE;
         cfg_ff.use_color_map <= 1'b0;
         cfg_ff.repeat_count  <= tpfc_pkg::REP_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpfc_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_pixel_word  (req_pixel_word),
      .req_line_start  (req_line_start),
      .queue_count     (queue_count),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   tpfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (queue_count)
   );

   tpfc_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the texture pixel format converter. Table loads and
// pixel beats are queued per mode, a mirror of the table and pairing state
// predicts every ARGB result beat, and each accepted result beat is compared
// with the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 12;
   localparam int LONG_HOLD      = 60;
   localparam int WATCHDOG_LIMIT = 1000;

   // source formats that convert nothing
   localparam logic [tpfc_pkg::FMT_W-1:0] FMT_UNUSED_FIRST = 3'd5;
   localparam logic [tpfc_pkg::FMT_W-1:0] FMT_UNUSED_LAST  = 3'd7;

   // table pages used by the channel map; the luma map shares the blue page
   localparam logic [7:0] BLUE_PAGE  = 8'h00;
   localparam logic [7:0] GREEN_PAGE = 8'h01;
   localparam logic [7:0] RED_PAGE   = 8'h02;

   typedef struct {
      logic        opcode;
      logic [15:0] index;
      logic [31:0] value;
      logic [31:0] pixel;
      logic        line_start;
   } texel_cmd_type;

   typedef struct {
      logic [31:0] pixel;
      logic        last;
   } argb_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_write_en   = 1'b0;
   logic [tpfc_pkg::CSR_INDEX_W-1:0] csr_index      = '0;
   logic [tpfc_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_opcode      = tpfc_pkg::OP_WRITE;
   logic [15:0] req_table_index = '0;
   logic [31:0] req_table_value = '0;
   logic [31:0] req_pixel_word  = '0;
   logic        req_line_start  = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic        rsp_last_of_run;

   // stimulus side
   texel_cmd_type texel_backlog [$];
   texel_cmd_type on_wire;
   logic        beat_taken = 1'b0;
   int          send_gap   = 0;
   int          stall_left = 0;
   logic        idle_on      = 1'b1;
   logic        hold_request = 1'b0;

   // what the generator knows has been loaded, so no unwritten entry is read
   bit          entry_loaded [0:65535];
   logic [15:0] written_index [$];
   logic [7:0]  blue_written [$];
   logic [7:0]  green_written [$];
   logic [7:0]  red_written [$];

   // mirror of the block used for prediction
   logic [31:0]       lut_mirror [0:65535];
   tpfc_pkg::cfg_type mirror_cfg = '{tpfc_pkg::FMT_PAL_OPAQUE, 1'b0, 4'd1};
   logic              yuy_half   = 1'b0;
   logic [15:0]       yuy_held   = '0;
   argb_beat_type     argb_due [$];
   argb_beat_type     head;

   int          fail_count  = 0;
   int          quiet_cycles = 0;

   texture_pixel_format_converter_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_pixel_word  (req_pixel_word),
      .req_line_start  (req_line_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // BT.601 channel: drop negatives, scale down by 256, saturate at 255
   function automatic logic [7:0] clamp_channel(input int v);
      if (v < 0) return 8'd0;
      if ((v >>> 8) > 255) return 8'hff;
      return v[15:8];
   endfunction

   function automatic logic [31:0] yuv_pixel(input logic [7:0] y, input logic [7:0] cb,
                                             input logic [7:0] cr);
      int c, d, e;
      c = 298 * int'(y) - 298 * 16;
      d = int'(cb) - 128;
      e = int'(cr) - 128;
      return {8'hff, clamp_channel(c + 409 * e + 128),
              clamp_channel(c - 100 * d - 208 * e + 128),
              clamp_channel(c + 516 * d + 128)};
   endfunction

   function automatic logic [31:0] mapped_channels(input logic [31:0] px);
      return lut_mirror[{RED_PAGE, px[23:16]}] | lut_mirror[{GREEN_PAGE, px[15:8]}]
           | lut_mirror[{BLUE_PAGE, px[7:0]}];
   endfunction

   function automatic logic [7:0] luma_of(input logic [15:0] px);
      return mirror_cfg.use_color_map ? lut_mirror[{BLUE_PAGE, px[15:8]}][7:0] : px[15:8];
   endfunction

   // Work out the result beats of one accepted request beat and queue them
   task automatic predict_argb(input texel_cmd_type c);
      logic [31:0] outs [$];
      logic [31:0] first_argb, second_argb;
      int          copies;
      if (c.opcode == tpfc_pkg::OP_WRITE) begin
         lut_mirror[c.index] = c.value;
         return;
      end
      // a line start always restarts the pairing, whatever the format
      if (c.line_start) yuy_half = 1'b0;
      case (mirror_cfg.source_format)
         tpfc_pkg::FMT_PAL_OPAQUE: outs.push_back(32'hff00_0000 | lut_mirror[c.pixel[15:0]]);
         tpfc_pkg::FMT_PAL_ALPHA:  outs.push_back(lut_mirror[c.pixel[15:0]]);
         tpfc_pkg::FMT_RGB32:
            outs.push_back(32'hff00_0000 |
                           (mirror_cfg.use_color_map ? mapped_channels(c.pixel) : c.pixel));
         tpfc_pkg::FMT_ARGB32:
            outs.push_back(mirror_cfg.use_color_map ?
                           ({c.pixel[31:24], 24'h0} | mapped_channels(c.pixel)) : c.pixel);
         tpfc_pkg::FMT_YUY16: begin
            if (!yuy_half) begin
               // first of a pair: hold it, nothing comes out yet
               yuy_held = c.pixel[15:0];
               yuy_half = 1'b1;
            end else begin
               copies = mirror_cfg.repeat_count;
               if (copies < 1) copies = 1;
               if (copies > tpfc_pkg::REP_CAP) copies = tpfc_pkg::REP_CAP;
               first_argb  = yuv_pixel(luma_of(yuy_held), yuy_held[7:0], c.pixel[7:0]);
               second_argb = yuv_pixel(luma_of(c.pixel[15:0]), yuy_held[7:0], c.pixel[7:0]);
               repeat (copies) outs.push_back(first_argb);
               repeat (copies) outs.push_back(second_argb);
               yuy_half = 1'b0;
            end
         end
         default: ;
      endcase
      foreach (outs[k]) argb_due.push_back('{outs[k], k == outs.size() - 1});
   endtask

   // ------------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------------

   function automatic void load_entry(input logic [15:0] idx, input logic [31:0] data);
      texel_cmd_type c;
      c.opcode     = tpfc_pkg::OP_WRITE;
      c.index      = idx;
      c.value      = data;
      c.pixel      = $urandom();   // ignored by a table write
      c.line_start = 1'($urandom_range(0, 1));
      texel_backlog.push_back(c);
      if (!entry_loaded[idx]) begin
         entry_loaded[idx] = 1'b1;
         written_index.push_back(idx);
         case (idx[15:8])
            BLUE_PAGE:  blue_written.push_back(idx[7:0]);
            GREEN_PAGE: green_written.push_back(idx[7:0]);
            RED_PAGE:   red_written.push_back(idx[7:0]);
            default: ;
         endcase
      end
   endfunction

   function automatic void queue_pixel(input logic [31:0] px, input logic ls);
      texel_cmd_type c;
      c.opcode     = tpfc_pkg::OP_CONVERT;
      c.index      = 16'($urandom());
      c.value      = $urandom();
      c.pixel      = px;
      c.line_start = ls;
      texel_backlog.push_back(c);
   endfunction

   // Random pixel whose table lookups only touch loaded entries
   function automatic logic [31:0] legal_pixel(input logic [tpfc_pkg::FMT_W-1:0] fmt,
                                               input logic map);
      logic [31:0] px;
      px = $urandom();
      case (fmt)
         tpfc_pkg::FMT_PAL_OPAQUE, tpfc_pkg::FMT_PAL_ALPHA:
            px[15:0] = written_index[$urandom_range(0, written_index.size() - 1)];
         tpfc_pkg::FMT_RGB32, tpfc_pkg::FMT_ARGB32:
            if (map) begin
               px[23:16] = red_written[$urandom_range(0, red_written.size() - 1)];
               px[15:8]  = green_written[$urandom_range(0, green_written.size() - 1)];
               px[7:0]   = blue_written[$urandom_range(0, blue_written.size() - 1)];
            end
         tpfc_pkg::FMT_YUY16:
            if (map) px[15:8] = blue_written[$urandom_range(0, blue_written.size() - 1)];
         default: ;
      endcase
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // Register writes and phase control
   // ------------------------------------------------------------------------

   // Hold back until every queued beat has gone in and every prediction has
   // been matched, then let the pipeline empty of beats that give no result
   task automatic settle();
      while (texel_backlog.size() != 0 || req_valid || argb_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [tpfc_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [tpfc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
   endtask

   task automatic set_mode(input logic [tpfc_pkg::FMT_W-1:0] fmt, input logic map,
                           input logic [tpfc_pkg::REP_W-1:0] rep);
      write_register(tpfc_pkg::CSR_SOURCE_FORMAT, {1'b0, fmt});
      write_register(tpfc_pkg::CSR_USE_COLOR_MAP, {3'b000, map});
      write_register(tpfc_pkg::CSR_REPEAT_COUNT, rep);
      @(negedge clock) csr_write_en <= 1'b0;
      mirror_cfg = '{fmt, map, rep};
   endtask

   // One random phase: mostly pixels in the chosen mode, some table loads,
   // a pixel in first place always opening a line so yuy16 pairs start clean
   task automatic run_random(input logic [tpfc_pkg::FMT_W-1:0] fmt, input logic map,
                             input logic [tpfc_pkg::REP_W-1:0] rep, input int count,
                             input logic long_hold);
      settle();
      set_mode(fmt, map, rep);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 2) != 0)
               load_entry(16'($urandom_range(0, 16'h02ff)), $urandom());
            else
               load_entry(16'($urandom_range(0, 16'hffff)), $urandom());
         end else begin
            queue_pixel(legal_pixel(fmt, map), k == 0 || $urandom_range(0, 7) == 0);
         end
      end
      // starve the result side so the block backs up into its input
      if (long_hold) hold_request = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Request driver: present a new beat only once the last one was taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      beat_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         beat_taken = 1'b1;
         predict_argb(on_wire);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (texel_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            // idle burst: hold the request off
            send_gap = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else begin
            on_wire = texel_backlog.pop_front();
            req_opcode      <= on_wire.opcode;
            req_table_index <= on_wire.index;
            req_table_value <= on_wire.value;
            req_pixel_word  <= on_wire.pixel;
            req_line_start  <= on_wire.line_start;
            req_valid       <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: stall in bursts, or for a long stretch on request
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left   = LONG_HOLD - 1;
         rsp_stall   <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (argb_due.size() == 0) begin
            $error("result beat with nothing predicted: pixel_out %h last_of_run %b",
                   rsp_pixel_out, rsp_last_of_run);
            fail_count++;
         end else begin
            head = argb_due.pop_front();
            if (rsp_pixel_out !== head.pixel) begin
               $error("pixel_out: expected %h, actual %h", head.pixel, rsp_pixel_out);
               fail_count++;
            end
            if (rsp_last_of_run !== head.last) begin
               $error("last_of_run: expected %b, actual %b", head.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // Count cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Load the corners of the table and of each map page; value extremes
      load_entry(16'hffff, 32'hffff_ffff);
      load_entry(16'h0000, 32'h0000_0000);
      load_entry(16'h00ff, $urandom());
      load_entry(16'h0100, $urandom());
      load_entry(16'h01ff, $urandom());
      load_entry(16'h0200, $urandom());
      load_entry(16'h02ff, $urandom());

      // palette opaque straight out of reset, then palette with table alpha
      queue_pixel(32'h0000_ffff, 1'b0);
      settle();
      set_mode(tpfc_pkg::FMT_PAL_ALPHA, 1'b0, 4'd1);
      queue_pixel(32'hffff_0000, 1'b1);

      // pass-through and channel map at the ends of every page
      settle();
      set_mode(tpfc_pkg::FMT_RGB32, 1'b0, 4'd1);
      queue_pixel(32'hffff_ffff, 1'b0);
      settle();
      set_mode(tpfc_pkg::FMT_RGB32, 1'b1, 4'd1);
      queue_pixel(32'h00ff_ffff, 1'b0);
      settle();
      set_mode(tpfc_pkg::FMT_ARGB32, 1'b0, 4'd1);
      queue_pixel(32'h0000_0000, 1'b0);
      settle();
      set_mode(tpfc_pkg::FMT_ARGB32, 1'b1, 4'd1);
      queue_pixel(32'h5a00_0000, 1'b0);

      // yuy16: full luma with chroma clipping both ways, zero luma, and a
      // line start that lands on the second pixel of a pair
      settle();
      set_mode(tpfc_pkg::FMT_YUY16, 1'b0, 4'd1);
      queue_pixel(32'h0000_ff00, 1'b1);
      queue_pixel(32'hffff_00ff, 1'b0);
      queue_pixel(32'h0000_00ff, 1'b1);
      queue_pixel(32'h0000_1000, 1'b0);
      queue_pixel(32'h0000_8080, 1'b1);
      queue_pixel(32'h0000_8080, 1'b1);
      queue_pixel(32'h0000_8080, 1'b0);

      // undefined format swallows the pixel
      settle();
      set_mode(FMT_UNUSED_FIRST, 1'b0, 4'd1);
      queue_pixel($urandom(), 1'b1);

      // random phases across the register settings, extremes included
      run_random(tpfc_pkg::FMT_PAL_OPAQUE, 1'b0, 4'd1, 25, 1'b0);
      run_random(tpfc_pkg::FMT_PAL_ALPHA, 1'b1, 4'd4, 25, 1'b0);
      run_random(tpfc_pkg::FMT_RGB32, 1'b1, 4'd1, 20, 1'b1);
      run_random(tpfc_pkg::FMT_ARGB32, 1'b0, 4'd6, 20, 1'b0);
      run_random(tpfc_pkg::FMT_ARGB32, 1'b1, 4'd2, 20, 1'b0);
      run_random(tpfc_pkg::FMT_YUY16, 1'b0, 4'd8, 20, 1'b0);
      run_random(tpfc_pkg::FMT_YUY16, 1'b1, 4'd0, 25, 1'b0);
      run_random(tpfc_pkg::FMT_YUY16, 1'b1, 4'd15, 20, 1'b1);
      run_random(FMT_UNUSED_LAST, 1'b1, 4'd3, 10, 1'b0);
      run_random(tpfc_pkg::FMT_RGB32, 1'b0, 4'd5, 20, 1'b0);

      // last stretch with both sides running flat out
      settle();
      idle_on = 1'b0;
      run_random(tpfc_pkg::FMT_YUY16, 1'b1, 4'd2, 20, 1'b0);
      run_random(tpfc_pkg::FMT_PAL_OPAQUE, 1'b0, 4'd1, 20, 1'b0);
      settle();

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tpfc_pkg.sv
hdl/tpfc_front.sv
hdl/tpfc_queue.sv
hdl/tpfc_back.sv
hdl/texture_pixel_format_converter_unit.sv
tb/testbench.sv
